// ----- hdl/wbpc_pkg.sv -----
// Package for the wildcard bit-pattern cluster checker.
// Holds shared widths, register indexes and the control word handed along the cell chain.
// No dependencies.
package wbpc_pkg;

    localparam int DATA_W  = 8;   // bits per cluster byte, one cell per bit
    localparam int LEN_W   = 7;   // pattern length register width
    localparam int HIT_W   = 5;   // per-byte hit count, up to sixteen
    localparam int COUNT_W = 16;  // saturating match count
    localparam int APB_DW  = 64;
    localparam int APB_AW  = 6;
    localparam int NUM_PAT = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX         = 16'hFFFF;
    localparam logic [COUNT_W-1:0] MAX_MATCHES_RESET = 16'd19;

    // Register indexes, paddr[5:3]
    localparam logic [2:0] REG_A_BITS      = 3'd0;
    localparam logic [2:0] REG_A_CARE      = 3'd1;
    localparam logic [2:0] REG_A_LEN       = 3'd2;
    localparam logic [2:0] REG_B_BITS      = 3'd3;
    localparam logic [2:0] REG_B_CARE      = 3'd4;
    localparam logic [2:0] REG_B_LEN       = 3'd5;
    localparam logic [2:0] REG_MAX_MATCHES = 3'd6;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [LEN_W-1:0] pre;   // cluster bits before this byte, saturated at 64
        logic [HIT_W-1:0] hits;  // matches found so far for this byte
    } stage_ctrl_t;

endpackage

// ----- hdl/wbpc_cell.sv -----
// One bit-alignment cell of the checker chain.
// Depends on wbpc_pkg for the stage control word.
module wbpc_cell #(
    parameter int PATTERN_BITS = 64,
    parameter int IDX          = 0
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic [PATTERN_BITS+7:0]     win_i,
    input  wbpc_pkg::stage_ctrl_t       ctrl_i,
    input  logic [PATTERN_BITS-1:0]     pat_bits [wbpc_pkg::NUM_PAT],
    input  logic [PATTERN_BITS-1:0]     pat_care [wbpc_pkg::NUM_PAT],
    input  logic [wbpc_pkg::LEN_W-1:0]  pat_len  [wbpc_pkg::NUM_PAT],
    output logic [PATTERN_BITS+7:0]     win_o,
    output wbpc_pkg::stage_ctrl_t       ctrl_o
);
    import wbpc_pkg::*;

    localparam int HW  = PATTERN_BITS;
    localparam int LSB = DATA_W - 1 - IDX;

    logic [HW-1:0]    slice;
    logic [LEN_W:0]   seen;
    logic [HIT_W-1:0] hits_next;
    logic             valid_reg;
    stage_ctrl_t      ctrl_reg;
    stage_ctrl_t      ctrl_next;
    logic [HW+7:0]    win_reg;

    // history as it stands once this cell's bit has been shifted in
    assign slice = win_i[LSB +: HW];
    assign seen  = {1'b0, ctrl_i.pre} + (LEN_W+1)'(IDX + 1);

    always_comb begin
        hits_next = ctrl_i.hits;
        for (int p = 0; p < NUM_PAT; p++) begin
            if ((pat_len[p] != '0) && (seen >= {1'b0, pat_len[p]}) &&
                (((slice ^ pat_bits[p]) & pat_care[p]) == '0)) begin
                hits_next = hits_next + HIT_W'(1);
            end
        end
        ctrl_next      = ctrl_i;
        ctrl_next.hits = hits_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= ctrl_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            win_reg  <= win_i;
            ctrl_reg <= ctrl_next;
        end
    end

    always_comb begin
        ctrl_o       = ctrl_reg;
        ctrl_o.valid = valid_reg;
    end

    assign win_o = win_reg;

endmodule

// ----- hdl/wbpc_accum.sv -----
// Tail of the checker chain: running cluster count, pass decision and result register.
// Depends on wbpc_pkg for the stage control word and count constants.
module wbpc_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  wbpc_pkg::stage_ctrl_t         tail,
    input  logic [wbpc_pkg::COUNT_W-1:0]  max_matches,
    input  logic                          m_ready,
    output logic                          adv,
    output logic                          m_valid,
    output logic                          m_cluster_ok,
    output logic [wbpc_pkg::COUNT_W-1:0]  m_match_count
);
    import wbpc_pkg::*;

    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] sat;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               load;

    assign sum  = {1'b0, total_reg} + (COUNT_W+1)'(tail.hits);
    assign sat  = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    // hold the chain only when a second result would land on a waiting one
    assign adv  = !(tail.valid && tail.last && out_valid_reg && !m_ready);
    assign load = adv && tail.valid && tail.last;

    always_comb begin
        total_next = total_reg;
        if (adv && tail.valid) begin
            total_next = tail.last ? '0 : sat;
        end
        out_valid_next = load || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            count_reg <= sat;
            ok_reg    <= (sat != '0) && (sat <= max_matches);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_cluster_ok  = ok_reg;
    assign m_match_count = count_reg;

endmodule

// ----- hdl/wildcard_bit_pattern_cluster_check_unit.sv -----
// Wildcard bit-pattern cluster checker: counts, over one cluster of bytes taken MSB first,
// the matches of each of two don't-care patterns at every bit alignment, and on the last
// byte returns the saturated count and a pass flag (one to max_matches inclusive). It takes
// one byte item every cycle; each byte passes a feed register, a chain of eight alignment
// cells (one per bit of the byte, each testing both patterns) and then the count register.
// The input stalls only when a cluster result reaches the chain's end while the previous
// result is still not taken. A byte that brings a cluster to CLUSTER_BYTES bytes closes it
// regardless of last_byte. Configuration goes through the APB port (64-bit data, register i
// at 8*i) and must be written only while no item is in flight. There is no clearing pass
// after reset. Depends on wbpc_pkg, wbpc_cell and wbpc_accum.
module wildcard_bit_pattern_cluster_check_unit #(
    parameter int CLUSTER_BYTES = 4096,
    parameter int PATTERN_BITS  = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wbpc_pkg::DATA_W-1:0]   s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_cluster_ok,
    output logic [wbpc_pkg::COUNT_W-1:0]  m_match_count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbpc_pkg::APB_AW-1:0]   paddr,
    input  logic [wbpc_pkg::APB_DW-1:0]   pwdata,
    output logic [wbpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import wbpc_pkg::*;

    localparam int HW     = PATTERN_BITS;
    localparam int WW     = HW + DATA_W;
    localparam int NCELL  = DATA_W;
    localparam int CNT_W  = ($clog2(CLUSTER_BYTES) < 4) ? 4 : $clog2(CLUSTER_BYTES);
    localparam logic [CNT_W-1:0] END_CNT = CNT_W'(CLUSTER_BYTES - 1);

    // ---------------------------------------------------------------- configuration
    logic [APB_DW-1:0]  bits_reg [NUM_PAT];
    logic [APB_DW-1:0]  care_reg [NUM_PAT];
    logic [LEN_W-1:0]   len_reg  [NUM_PAT];
    logic [COUNT_W-1:0] max_matches_reg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_AW-1:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NUM_PAT; p++) begin
                bits_reg[p] <= '0;
                care_reg[p] <= '0;
                len_reg[p]  <= '0;
            end
            max_matches_reg <= MAX_MATCHES_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_A_BITS:      bits_reg[0]     <= pwdata;
                REG_A_CARE:      care_reg[0]     <= pwdata;
                REG_A_LEN:       len_reg[0]      <= pwdata[LEN_W-1:0];
                REG_B_BITS:      bits_reg[1]     <= pwdata;
                REG_B_CARE:      care_reg[1]     <= pwdata;
                REG_B_LEN:       len_reg[1]      <= pwdata[LEN_W-1:0];
                REG_MAX_MATCHES: max_matches_reg <= pwdata[COUNT_W-1:0];
                default: ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_A_BITS:      prdata = bits_reg[0];
            REG_A_CARE:      prdata = care_reg[0];
            REG_A_LEN:       prdata = APB_DW'(len_reg[0]);
            REG_B_BITS:      prdata = bits_reg[1];
            REG_B_CARE:      prdata = care_reg[1];
            REG_B_LEN:       prdata = APB_DW'(len_reg[1]);
            REG_MAX_MATCHES: prdata = APB_DW'(max_matches_reg);
            default:         prdata = '0;
        endcase
    end

    // Effective patterns: clamp the length to the history width and fold the length
    // into the care mask, so each cell needs only one masked compare per pattern.
    logic [HW-1:0]    pat_bits [NUM_PAT];
    logic [HW-1:0]    pat_care [NUM_PAT];
    logic [LEN_W-1:0] pat_len  [NUM_PAT];

    always_comb begin
        for (int p = 0; p < NUM_PAT; p++) begin
            pat_len[p]  = (len_reg[p] > LEN_W'(HW)) ? LEN_W'(HW) : len_reg[p];
            pat_bits[p] = bits_reg[p][HW-1:0];
            for (int i = 0; i < HW; i++) begin
                pat_care[p][i] = care_reg[p][i] && (LEN_W'(i) < pat_len[p]);
            end
        end
    end

    // ---------------------------------------------------------------- feed stage
    // History and byte count depend only on the bytes themselves, so keep them here
    // and hand each cell the full window it needs.
    logic [HW-1:0]    hist_reg,  hist_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             accept;
    logic             adv;
    logic             cluster_end;
    logic [WW-1:0]    win_in;
    logic [LEN_W-1:0] pre_in;
    logic             feed_valid_reg;
    logic             feed_last_reg;
    logic [LEN_W-1:0] feed_pre_reg;
    logic [WW-1:0]    win  [NCELL];
    stage_ctrl_t      ctrl [NCELL+1];

    assign s_ready     = adv;
    assign accept      = s_valid && s_ready;
    assign win_in      = {hist_reg, s_data_byte};
    assign cluster_end = s_last_byte || (byte_cnt_reg == END_CNT);
    // bits of this cluster already taken in, saturated at 64
    assign pre_in      = (byte_cnt_reg >= CNT_W'(8)) ? LEN_W'(64)
                                                     : LEN_W'({byte_cnt_reg[2:0], 3'b000});

    always_comb begin
        hist_next     = hist_reg;
        byte_cnt_next = byte_cnt_reg;
        if (accept) begin
            hist_next     = cluster_end ? '0 : win_in[HW-1:0];
            byte_cnt_next = cluster_end ? '0 : byte_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg       <= '0;
            byte_cnt_reg   <= '0;
            feed_valid_reg <= 1'b0;
        end else begin
            hist_reg     <= hist_next;
            byte_cnt_reg <= byte_cnt_next;
            if (adv) begin
                feed_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            win[0]        <= win_in;
            feed_last_reg <= cluster_end;
            feed_pre_reg  <= pre_in;
        end
    end

    always_comb begin
        ctrl[0].valid = feed_valid_reg;
        ctrl[0].last  = feed_last_reg;
        ctrl[0].pre   = feed_pre_reg;
        ctrl[0].hits  = '0;
    end

    // ---------------------------------------------------------------- cell chain
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g < NCELL - 1) begin : g_mid
            wbpc_cell #(.PATTERN_BITS(PATTERN_BITS), .IDX(g)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .adv      (adv),
                .win_i    (win[g]),
                .ctrl_i   (ctrl[g]),
                .pat_bits (pat_bits),
                .pat_care (pat_care),
                .pat_len  (pat_len),
                .win_o    (win[g+1]),
                .ctrl_o   (ctrl[g+1])
            );
        end else begin : g_end
            // the last cell's window goes nowhere
            wbpc_cell #(.PATTERN_BITS(PATTERN_BITS), .IDX(g)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .adv      (adv),
                .win_i    (win[g]),
                .ctrl_i   (ctrl[g]),
                .pat_bits (pat_bits),
                .pat_care (pat_care),
                .pat_len  (pat_len),
                .win_o    (),
                .ctrl_o   (ctrl[g+1])
            );
        end
    end

    // ---------------------------------------------------------------- count and result
    wbpc_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .tail          (ctrl[NCELL]),
        .max_matches   (max_matches_reg),
        .m_ready       (m_ready),
        .adv           (adv),
        .m_valid       (m_valid),
        .m_cluster_ok  (m_cluster_ok),
        .m_match_count (m_match_count)
    );

endmodule

// ----- hdl/wbpc_checker.sv -----
// Port-level checks for the wildcard bit-pattern cluster checker, bound to the top level.
// Sees only top-level ports; no package needed.
module wbpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_cluster_ok,
    input logic [15:0] m_match_count,
    input logic        pready
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_count) && $stable(m_cluster_ok))
        else $error("result changed while stalled");

    // a pass needs at least one match
    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cluster_ok |-> m_match_count != 16'd0)
        else $error("pass flag with zero count");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind wildcard_bit_pattern_cluster_check_unit wbpc_checker u_wbpc_checker (.*);
